// File: sv/spd_pkg.sv
package spd_pkg;

  localparam int unsigned ValW   = 62;
  localparam int unsigned HlenW  = 5;
  localparam int unsigned LeftW  = 4;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ValW-1:0] BidiCodepointRst = ValW'(65);
  localparam logic [ValW-1:0] UniCodepointRst  = ValW'(84);

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgExpectedKind = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBidiCp       = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgUniCp        = 2'd2;

  typedef enum logic [1:0] {
    StNeedMore   = 2'd0,
    StComplete   = 2'd1,
    StUnexpected = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PhType    = 2'd0,
    PhSession = 2'd1,
    PhPoison  = 2'd2
  } phase_e;

  typedef enum logic {
    OpByte    = 1'b0,
    OpRestart = 1'b1
  } op_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             byte_taken;
    logic [ValW-1:0]  sess_val;
    logic [ValW-1:0]  type_val;
    logic [HlenW-1:0] hdr_len;
  } out_item_t;

  // Classified item handed from front to back
  typedef struct packed {
    op_e        op;
    logic [1:0] len_code;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic            expected_kind;
    logic [ValW-1:0] bidi_cp;
    logic [ValW-1:0] uni_cp;
  } cfg_t;

  // Bytes still to come after the first byte of a varint
  function automatic logic [LeftW-1:0] varint_left(input logic [1:0] len_code);
    logic [LeftW-1:0] r;
    unique case (len_code)
      2'd0:    r = LeftW'(0);
      2'd1:    r = LeftW'(1);
      2'd2:    r = LeftW'(3);
      default: r = LeftW'(7);
    endcase
    return r;
  endfunction

endpackage

// File: sv/spd_front.sv
module spd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  spd_pkg::in_item_t item_i,
  output logic              full_o,
  output logic              cmd_valid_o,
  output spd_pkg::cmd_t     cmd_o,
  input  logic              cmd_take_i
);
  import spd_pkg::*;

  cmd_t       buf_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_take;
  cmd_t       cmd_new;

  assign full_o      = (count_q == 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = buf_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_take     = cmd_take_i && cmd_valid_o;

  always_comb begin
    cmd_new.op       = item_i.kind ? OpRestart : OpByte;
    cmd_new.len_code = item_i.data_byte[7:6];
    cmd_new.data     = item_i.data_byte;
  end

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_take ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_take) begin
      count_d = count_q + 2'd1;
    end else if (!do_push && do_take) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_ptr_q] <= cmd_new;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("front queue overflow");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q)) else $error("front pointer mismatch");
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_take) |=> (count_q == $past(count_q) + 2'd1))
    else $error("front count did not grow");
`endif

endmodule

// File: sv/spd_back.sv
module spd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spd_pkg::cfg_t      cfg_i,
  input  logic               cmd_valid_i,
  input  spd_pkg::cmd_t      cmd_i,
  output logic               cmd_take_o,
  output logic               empty_o,
  input  logic               pop_i,
  output spd_pkg::out_item_t item_o
);
  import spd_pkg::*;

  phase_e           phase_q, phase_d;
  logic [ValW-1:0]  accum_q, accum_d;
  logic [LeftW-1:0] left_q, left_d;
  logic [ValW-1:0]  saved_q, saved_d;
  logic [HlenW-1:0] seen_q, seen_d;

  out_item_t  res;
  out_item_t  oq_q [2];
  logic       owr_q, ord_q;
  logic [1:0] ocount_q, ocount_d;
  logic       do_pop;

  logic [ValW-1:0]  v;
  logic [LeftW-1:0] left_n;
  logic [HlenW-1:0] seen_n;
  logic [ValW-1:0]  want;

  assign empty_o    = (ocount_q == 2'd0);
  assign item_o     = oq_q[ord_q];
  assign do_pop     = pop_i && !empty_o;
  assign cmd_take_o = cmd_valid_i && ((ocount_q != 2'd2) || do_pop);
  assign want       = cfg_i.expected_kind ? cfg_i.uni_cp : cfg_i.bidi_cp;

  // Varint step on the incoming byte
  always_comb begin
    if (left_q == '0) begin
      v      = {{(ValW-6){1'b0}}, cmd_i.data[5:0]};
      left_n = varint_left(cmd_i.len_code);
    end else begin
      v      = {accum_q[ValW-9:0], cmd_i.data};
      left_n = left_q - LeftW'(1);
    end
    seen_n = seen_q + HlenW'(1);
  end

  always_comb begin
    phase_d = phase_q;
    accum_d = accum_q;
    left_d  = left_q;
    saved_d = saved_q;
    seen_d  = seen_q;
    res     = '0;
    if (cmd_i.op == OpRestart) begin
      phase_d = PhType;
      accum_d = '0;
      left_d  = '0;
      saved_d = '0;
      seen_d  = '0;
    end else begin
      unique case (phase_q)
        PhType, PhSession: begin
          res.byte_taken = 1'b1;
          accum_d = v;
          left_d  = left_n;
          seen_d  = seen_n;
          if (left_n == '0) begin
            accum_d = '0;
            if (phase_q == PhType) begin
              saved_d = v;
              if (v != want) begin
                phase_d      = PhPoison;
                res.status   = StUnexpected;
                res.type_val = v;
              end else begin
                phase_d = PhSession;
              end
            end else begin
              res.status   = StComplete;
              res.sess_val = v;
              res.type_val = saved_q;
              res.hdr_len  = seen_n;
              phase_d = PhType;
              left_d  = '0;
              saved_d = '0;
              seen_d  = '0;
            end
          end
        end
        default: begin
          res.status   = StUnexpected;
          res.type_val = saved_q;
        end
      endcase
    end
  end

  always_comb begin
    ocount_d = ocount_q;
    if (cmd_take_o && !do_pop) begin
      ocount_d = ocount_q + 2'd1;
    end else if (!cmd_take_o && do_pop) begin
      ocount_d = ocount_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhType;
      accum_q  <= '0;
      left_q   <= '0;
      saved_q  <= '0;
      seen_q   <= '0;
      owr_q    <= 1'b0;
      ord_q    <= 1'b0;
      ocount_q <= 2'd0;
    end else begin
      if (cmd_take_o) begin
        phase_q <= phase_d;
        accum_q <= accum_d;
        left_q  <= left_d;
        saved_q <= saved_d;
        seen_q  <= seen_d;
        owr_q   <= ~owr_q;
      end
      if (do_pop) begin
        ord_q <= ~ord_q;
      end
      ocount_q <= ocount_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take_o) begin
      oq_q[owr_q] <= res;
    end
  end

`ifndef ASSERT_OFF
  a_oq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocount_q != 2'd3) else $error("result queue overflow");
  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_take_o && cmd_i.op == OpRestart) |=> (phase_q == PhType && left_q == '0 &&
    seen_q == '0)) else $error("restart did not clear decoder");
  a_complete_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_take_o && res.status == StComplete) |-> (res.byte_taken && phase_q == PhSession))
    else $error("completion outside session phase");
  a_poison_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhPoison && !(cmd_take_o && cmd_i.op == OpRestart)) |=> (phase_q == PhPoison))
    else $error("poisoned state left without restart");
`endif

endmodule

// File: sv/stream_preamble_decoder_unit.sv
// Stream preamble decoder: parses a type varint and a session-id varint from a byte stream.
// Input channel: queue style, push_i/full_o; a transaction carries a restart flag (kind)
//   and one stream byte. Each transaction yields exactly one result.
// Result channel: queue style, empty_o/pop_i; the oldest result sits on out_item_o while
//   empty_o is low and leaves on pop_i.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i (0 expected kind, 1 bidi
//   codepoint, 2 uni codepoint) and cfg_data_i; always ready, write only while idle.
// A pushed byte is registered in the front queue, then its result is registered in the result queue.
// Throughput: one byte per cycle while the result queue has room; the decoder applies one varint step
//   per cycle, set by the 62-bit shift/compare path from the front queue head to the result queue.
// Front and back are split by a 2-entry queue; results wait in a 2-entry queue, so a
//   stalled receiver backs up into full_o only once both queues are occupied.
// Reset: decoder returns to reading the type, queues empty, codepoints 65 and 84,
//   expected kind bidirectional.
module stream_preamble_decoder_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  output logic                        full_o,
  input  spd_pkg::in_item_t           in_item_i,
  output logic                        empty_o,
  input  logic                        pop_i,
  output spd_pkg::out_item_t          out_item_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [spd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [spd_pkg::ValW-1:0]    cfg_data_i
);
  import spd_pkg::*;

  cfg_t cfg_q;
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_kind <= 1'b0;
      cfg_q.bidi_cp       <= BidiCodepointRst;
      cfg_q.uni_cp        <= UniCodepointRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgExpectedKind: cfg_q.expected_kind <= cfg_data_i[0];
        CfgBidiCp:       cfg_q.bidi_cp       <= cfg_data_i;
        CfgUniCp:        cfg_q.uni_cp        <= cfg_data_i;
        default:         ;
      endcase
    end
  end

  spd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .item_i      (in_item_i),
    .full_o      (full_o),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  spd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .item_o      (out_item_o)
  );

endmodule
